[rtl/flux_transition_event_source_core_assert.svh]
// assertion helpers shared by the checker
// both expect clk and arst_n in scope
`ifndef FLUX_TRANSITION_EVENT_SOURCE_CORE_ASSERT_SVH
`define FLUX_TRANSITION_EVENT_SOURCE_CORE_ASSERT_SVH

// same-cycle implication
`define FTES_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FTES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ftes_pkg.sv]
package ftes_pkg;

	localparam int TIME_W     = 35;
	localparam int HALF_W     = 16;
	localparam int CELL_W     = HALF_W + 1;
	localparam int BCNT_W     = 18;
	localparam int IDX_W      = 14;
	localparam int BYTE_W     = 8;
	localparam int OP_W       = 2;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int DIV_CNT_W  = $clog2(TIME_W + 1);

	localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(1);

	// register index, taken from paddr[2]
	localparam logic REG_HALF_BIT_TIME = 1'b0;
	localparam logic REG_BIT_COUNT     = 1'b1;

	localparam logic ANS_EVENT = 1'b0;
	localparam logic ANS_SEEK  = 1'b1;

	localparam logic EVT_FLUX  = 1'b0;
	localparam logic EVT_INDEX = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_RESET = 2'd1,
		OP_NEXT  = 2'd2,
		OP_SEEK  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVT,
		S_SCAN,
		S_SLEN,
		S_SCHK,
		S_SDIV,
		S_RESP
	} state_t;

endpackage

[rtl/ftes_store.sv]
module ftes_store
	import ftes_pkg::*;
#(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/ftes_div.sv]
module ftes_div
	import ftes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [CELL_W-1:0] divisor,
	output logic              done,
	output logic [TIME_W-1:0] quo,
	output logic [CELL_W-1:0] rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    quo_q;
	logic [CELL_W-1:0]    rem_q;
	logic [CELL_W-1:0]    div_q;
	logic [CELL_W:0]      trial;
	logic [CELL_W:0]      diff;
	logic                 ge;

	// restoring division, one quotient bit a cycle
	always_comb begin
		trial = {rem_q, quo_q[TIME_W-1]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(TIME_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TIME_W-2:0], ge};
			rem_q <= ge ? diff[CELL_W-1:0] : trial[CELL_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/flux_transition_event_source_core.sv]
// Flux transition event source. Bytes of a disk track are loaded into an on-chip store
// (MSB of each byte is the earliest bit); next-event requests then report the time to the
// next set bit in clock units, switching to index-hole events once bit_count bits are used,
// and seeks place the bit position from a time. Load and position reset are done on acceptance.
// A next-event request scans the store one byte at a time, and each byte needs one read of the
// single store port and a search of it; an index event that is due at once needs no scan.
// A seek runs the 35-step bit-serial divider and then takes its quotient; a seek landing at
// the end or before the first half bit does not use the divider. One item is in work at a
// time; the result register lets the next item enter while a result waits. The store has
// no reset and must be loaded before the bits it holds are scanned.
module flux_transition_event_source_core
	import ftes_pkg::*;
#(
	parameter int MAX_BITS = 131072
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [OP_W-1:0]       operation,
	input  logic [IDX_W-1:0]      byte_index,
	input  logic [BYTE_W-1:0]     byte_value,
	input  logic [TIME_W-1:0]     seek_time,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  answer_kind,
	output logic                  event_kind,
	output logic [TIME_W-1:0]     event_time,
	output logic [TIME_W-1:0]     reached_time
);

	localparam int STORE_BYTES = MAX_BITS / 8;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int POS_W       = $clog2(MAX_BITS + 2);
	localparam int LEN_W       = CELL_W + POS_W;
	localparam int CMP_W       = (LEN_W > TIME_W) ? LEN_W : TIME_W;

	state_t state_q, state_d;

	logic [HALF_W-1:0] half_bit_time_q;
	logic [BCNT_W-1:0] bit_count_q;
	logic [POS_W-1:0]  pos_q;
	logic              exh_q;
	logic [TIME_W-1:0] t_q;
	logic              kind_q;
	logic              ans_q;
	logic [TIME_W-1:0] reached_q;
	logic [TIME_W-1:0] target_q;
	logic [LEN_W-1:0]  length_q;
	logic              rd_ok_q;

	logic              rsp_valid_q;
	logic              answer_kind_q;
	logic              event_kind_q;
	logic [TIME_W-1:0] event_time_q;
	logic [TIME_W-1:0] reached_time_q;

	logic              req_acc;
	logic              cfg_wr;
	logic              out_free;
	logic [POS_W-1:0]  cnt;
	logic [CELL_W-1:0] cell_len;

	logic              st_we;
	logic [ADDR_W-1:0] st_waddr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;

	logic              div_start;
	logic              div_done;
	logic [TIME_W-1:0] div_quo;
	logic [CELL_W-1:0] div_rem;

	logic              seek_end;
	logic              seek_low;

	logic [POS_W-1:0]    scan_base;
	logic [POS_W-1:0]    scan_left;
	logic [3:0]          scan_lim;
	logic [3:0]          scan_off;
	logic [BYTE_W-1:0]   scan_data;
	logic                scan_found;
	logic [2:0]          scan_fj;
	logic [3:0]          scan_k;
	logic [CELL_W+3:0]   scan_step;
	logic [TIME_W-1:0]   scan_t;
	logic [POS_W-1:0]    scan_pos;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		case (paddr[2])
			REG_HALF_BIT_TIME: prdata = APB_DATA_W'(half_bit_time_q);
			REG_BIT_COUNT:     prdata = APB_DATA_W'(bit_count_q);
			default:           prdata = '0;
		endcase
	end

	// bit count clamped to the store size
	always_comb begin
		if (32'(bit_count_q) > MAX_BITS) begin
			cnt = POS_W'(MAX_BITS);
		end else begin
			cnt = POS_W'(bit_count_q);
		end
		cell_len = {half_bit_time_q, 1'b0};
	end

	assign st_we    = req_acc && (operation == OP_LOAD) && (32'(byte_index) < STORE_BYTES);
	assign st_waddr = ADDR_W'(byte_index);

	ftes_store #(
		.DEPTH (STORE_BYTES),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(byte_value),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	ftes_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(target_q - TIME_W'(half_bit_time_q)),
		.divisor (cell_len),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	// search the rest of the fetched byte for the first set bit below the bit count
	always_comb begin
		scan_base  = {pos_q[POS_W-1:3], 3'b000};
		scan_left  = cnt - scan_base;
		scan_lim   = (scan_left >= POS_W'(8)) ? 4'd8 : scan_left[3:0];
		scan_off   = {1'b0, pos_q[2:0]};
		scan_data  = rd_ok_q ? rd_data : '0;
		scan_found = 1'b0;
		scan_fj    = '0;
		for (int j = 7; j >= 0; j--) begin
			if (scan_data[7-j] && (4'(j) >= scan_off) && (4'(j) < scan_lim)) begin
				scan_found = 1'b1;
				scan_fj    = 3'(j);
			end
		end
		scan_k    = scan_found ? ({1'b0, scan_fj} + 4'd1 - scan_off) : (scan_lim - scan_off);
		scan_step = (CELL_W + 4)'(scan_k) * (CELL_W + 4)'(cell_len);
		scan_t    = t_q + TIME_W'(scan_step);
		scan_pos  = pos_q + POS_W'(scan_k);
	end

	always_comb begin
		seek_end = (CMP_W'(target_q) >= CMP_W'(length_q));
		seek_low = (target_q < TIME_W'(half_bit_time_q)) || (cell_len == '0);
	end

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = ADDR_W'(pos_q >> 3);
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					case (operation)
						OP_NEXT: state_d = S_EVT;
						OP_SEEK: state_d = S_SLEN;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_EVT: begin
				if (pos_q >= cnt) begin
					state_d = S_RESP;
				end else begin
					rd_en   = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				state_d = scan_found ? S_RESP : S_EVT;
			end
			S_SLEN: begin
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (seek_end || seek_low) begin
					state_d = S_RESP;
				end else begin
					div_start = 1'b1;
					state_d   = S_SDIV;
				end
			end
			S_SDIV: begin
				if (div_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			half_bit_time_q <= HALF_RESET;
			bit_count_q     <= '0;
			pos_q           <= '0;
			exh_q           <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (paddr[2])
					REG_HALF_BIT_TIME: half_bit_time_q <= pwdata[HALF_W-1:0];
					REG_BIT_COUNT:     bit_count_q     <= pwdata[BCNT_W-1:0];
					default:           ;
				endcase
			end
			if (state_q == S_RESP && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc && operation == OP_RESET) begin
						pos_q <= '0;
						exh_q <= 1'b0;
					end
				end
				S_EVT: begin
					if (pos_q >= cnt) begin
						exh_q <= 1'b1;
						if (pos_q == cnt) begin
							pos_q <= pos_q + POS_W'(1);
						end
					end
				end
				S_SCAN: begin
					pos_q <= scan_pos;
				end
				S_SCHK: begin
					exh_q <= seek_end;
					if (seek_end) begin
						pos_q <= cnt + POS_W'(1);
					end else if (seek_low) begin
						pos_q <= '0;
					end
				end
				S_SDIV: begin
					if (div_done) begin
						pos_q <= POS_W'(div_quo) + POS_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					ans_q    <= (operation == OP_SEEK) ? ANS_SEEK : ANS_EVENT;
					target_q <= seek_time;
					// first event is pulled back by half a bit
					t_q      <= (pos_q == '0) ? (TIME_W'(0) - TIME_W'(half_bit_time_q)) : '0;
				end
			end
			S_EVT: begin
				rd_ok_q <= (32'(pos_q >> 3) < STORE_BYTES);
				if (pos_q >= cnt) begin
					kind_q <= EVT_INDEX;
					if (pos_q == cnt) begin
						t_q <= t_q + TIME_W'(half_bit_time_q);
					end
				end
			end
			S_SCAN: begin
				t_q    <= scan_t;
				kind_q <= exh_q;
			end
			S_SLEN: begin
				length_q <= LEN_W'(cell_len) * LEN_W'(cnt);
			end
			S_SCHK: begin
				if (seek_end) begin
					reached_q <= TIME_W'(length_q);
				end else begin
					reached_q <= '0;
				end
			end
			S_SDIV: begin
				// h + cell_len * q is the target less the remainder
				if (div_done) begin
					reached_q <= target_q - TIME_W'(div_rem);
				end
			end
			S_RESP: begin
				if (out_free) begin
					answer_kind_q  <= ans_q;
					event_kind_q   <= (ans_q == ANS_SEEK) ? EVT_FLUX : kind_q;
					event_time_q   <= (ans_q == ANS_SEEK) ? '0 : t_q;
					reached_time_q <= (ans_q == ANS_SEEK) ? reached_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid    = rsp_valid_q;
	assign answer_kind  = answer_kind_q;
	assign event_kind   = event_kind_q;
	assign event_time   = event_time_q;
	assign reached_time = reached_time_q;

endmodule

[rtl/ftes_checker.sv]
`include "flux_transition_event_source_core_assert.svh"

module ftes_checker
	import ftes_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic [OP_W-1:0]   operation,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic              answer_kind,
	input logic              event_kind,
	input logic [TIME_W-1:0] event_time,
	input logic [TIME_W-1:0] reached_time
);

	`FTES_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(answer_kind) && $stable(event_kind) && $stable(event_time) && $stable(reached_time), "result beat changed while stalled")
	`FTES_ASSERT_IMPL(a_seek_fields, rsp_valid && answer_kind == ANS_SEEK, event_kind == EVT_FLUX && event_time == '0, "seek result carries event fields")
	`FTES_ASSERT_IMPL(a_event_fields, rsp_valid && answer_kind == ANS_EVENT, reached_time == '0, "event result carries a reached time")
	`FTES_ASSERT_NEXT(a_busy_after_query, req_valid && !req_stall && (operation == OP_NEXT || operation == OP_SEEK), req_stall, "query accepted without going busy")

endmodule

bind flux_transition_event_source_core ftes_checker u_ftes_checker (.*);
